// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- design/xcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// xcsd_pkg
// Constants, register indexes and helper functions of the XOR chain
// stream descrambler.
// ----------------------------------------------------------------------------
package xcsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 31;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned IdxW  = 1;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [ModeW-1:0] mode_t;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] REG_METHOD_MODE   = 1'd0;
  localparam logic [IdxW-1:0] REG_STREAM_LENGTH = 1'd1;

  // Mode codes
  localparam mode_t MODE_PLAIN = 2'd0;
  localparam mode_t MODE_TWO   = 2'd2;

  localparam byte_t MUL_DEFAULT  = 8'h6d;
  localparam byte_t MUL_MODE_TWO = 8'had;
  localparam byte_t FIXUP_MASK   = 8'h0d;

  // Lanes (position mod 16) that take the fixup
  localparam logic [3:0] FIXUP_LANE_A = 4'd5;
  localparam logic [3:0] FIXUP_LANE_B = 4'd6;

  localparam mode_t MODE_RESET   = MODE_PLAIN;
  localparam pos_t  LENGTH_RESET = 31'd1;

  function automatic byte_t key_lookup(input logic [3:0] lane);
    byte_t k;
    unique case (lane)
      4'h0: k = 8'h4f;
      4'h1: k = 8'hd0;
      4'h2: k = 8'ha0;
      4'h3: k = 8'hac;
      4'h4: k = 8'h4a;
      4'h5: k = 8'h5b;
      4'h6: k = 8'hb9;
      4'h7: k = 8'he5;
      4'h8: k = 8'h93;
      4'h9: k = 8'h79;
      4'ha: k = 8'h45;
      4'hb: k = 8'ha5;
      4'hc: k = 8'hc1;
      4'hd: k = 8'hcb;
      4'he: k = 8'h31;
      4'hf: k = 8'h93;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // Low byte of position times the mode multiplier
  function automatic byte_t ramp_byte(input byte_t pos_lo, input byte_t mul);
    logic [2*ByteW-1:0] prod;
    prod = pos_lo * mul;
    return prod[ByteW-1:0];
  endfunction

endpackage

// ----- design/xor_chain_stream_descrambler_unit.sv -----
// ----------------------------------------------------------------------------
// xor_chain_stream_descrambler_unit
// Byte stream descrambler: key table, position ramp and XOR chain, cut into
// buffers of a configured length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

// Descrambles one byte per transaction, one transaction per clock when the
// output side keeps up: each accepted byte at buffer position i is XORed with
// key[i mod 16] and low8(i*k) (k = 0xad in mode 2, else 0x6d) to form x, and
// the output is x XOR the previous x, seeded with the low byte of
// stream_length at position 0. In nonzero modes positions 5 and 6 of every 16
// are further XORed with 0x0d. last_byte flags the final byte of a buffer,
// after which the position and seed restart. The result is held in a result
// register; in_ready stays high while that register is empty or being
// drained, so throughput is one byte per cycle, limited only by the single
// result register and the downstream ready. Registers are written with cfg_we
// (index 0 method_mode, index 1 stream_length) and take effect on the next
// byte; write them only while the block is idle. A stream_length of 0 acts as
// 1 with a seed of 0.
module xor_chain_stream_descrambler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [xcsd_pkg::IdxW-1:0]       cfg_index,
  input  logic [xcsd_pkg::CfgW-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [xcsd_pkg::ByteW-1:0]      in_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xcsd_pkg::ByteW-1:0]      out_byte,
  output logic                            last_byte
);
  import xcsd_pkg::*;

  // Configuration registers
  mode_t method_mode;
  pos_t  stream_length;

  // Chain state
  pos_t  byte_position;
  byte_t chain_prev;

  // Datapath for the byte being accepted
  logic         in_fire;
  byte_t        mul;
  byte_t        seed;
  byte_t        prev_sel;
  byte_t        x_next;
  byte_t        out_byte_next;
  logic [3:0]   lane;
  logic [PosW:0] pos_inc;
  logic         last_next;

  // Result register drains or is empty: take a new byte
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    lane     = byte_position[3:0];
    mul      = (method_mode == MODE_TWO) ? MUL_MODE_TWO : MUL_DEFAULT;
    seed     = stream_length[ByteW-1:0];
    prev_sel = (byte_position == '0) ? seed : chain_prev;
    x_next   = in_byte ^ key_lookup(lane) ^ ramp_byte(byte_position[ByteW-1:0], mul);
    out_byte_next = x_next ^ prev_sel;
    if (method_mode != MODE_PLAIN && (lane == FIXUP_LANE_A || lane == FIXUP_LANE_B)) begin
      out_byte_next = out_byte_next ^ FIXUP_MASK;
    end
    // Compare one bit wider so the increment cannot wrap; the >= lets a length
    // change below the position still end the buffer
    pos_inc   = {1'b0, byte_position} + {{PosW{1'b0}}, 1'b1};
    last_next = pos_inc >= {1'b0, stream_length};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      method_mode   <= MODE_RESET;
      stream_length <= LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METHOD_MODE:   method_mode   <= cfg_data[ModeW-1:0];
        REG_STREAM_LENGTH: stream_length <= cfg_data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Chain state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      chain_prev    <= LENGTH_RESET[ByteW-1:0];
    end else if (in_fire) begin
      byte_position <= last_next ? '0 : pos_inc[PosW-1:0];
      chain_prev    <= x_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte  <= out_byte_next;
      last_byte <= last_next;
    end
  end

  // An accepted byte always shows up in the result register
  `ASSERT_NEXT(a_fire_gives_result, clk, rst, in_fire, out_valid)
  // The end of a buffer restarts the position
  `ASSERT_NEXT(a_last_restarts, clk, rst, in_fire && last_next, byte_position == '0)
  // Position moves only with an accepted transaction
  `ASSERT_NEXT(a_pos_holds, clk, rst, !in_fire, $stable(byte_position))
  // A stalled result never lets a new byte in
  `ASSERT_SAME(a_no_overrun, clk, rst, out_valid && !out_ready, !in_fire)

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR chain stream descrambler. It sends bytes
// with random gaps and back-pressure, predicts every output byte and
// end-of-buffer flag in a local model of the chain, and compares each
// transaction in order. It covers directed corner cases, then random buffers
// under a range of modes and lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import xcsd_pkg::*;

  // Mode codes that the package leaves unnamed; both enable the lane fixups.
  localparam mode_t MODE_FIX_A = 2'd1;
  localparam mode_t MODE_FIX_B = 2'd3;

  // Chain constants: key bytes packed lane 0 in the low byte.
  localparam logic [127:0] KEY_BYTES =
    128'h93_31_cb_c1_a5_45_79_93_e5_b9_5b_4a_ac_a0_d0_4f;
  localparam byte_t RAMP_MUL_STD = 8'h6d;
  localparam byte_t RAMP_MUL_ALT = 8'had;
  localparam byte_t LANE_FIX     = 8'h0d;
  localparam logic [3:0] FIX_LANE_LO = 4'd5;
  localparam logic [3:0] FIX_LANE_HI = 4'd6;

  localparam pos_t LEN_MAX      = 31'h7fff_ffff;
  localparam int   IDLE_PCT     = 34;
  localparam int   RANDOM_BYTES = 450;

  typedef struct packed {
    byte_t data;
    logic  last;
  } chain_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IdxW-1:0]   cfg_index = REG_METHOD_MODE;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  byte_t             in_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  byte_t             out_byte;
  logic              last_byte;

  // Local copy of the descrambler's registers and chain state.
  mode_t p_mode   = MODE_RESET;
  pos_t  p_length = LENGTH_RESET;
  pos_t  p_pos    = '0;
  byte_t p_chain  = LENGTH_RESET[7:0];

  chain_out_t expected_bytes[$];

  int unsigned err_count      = 0;
  int unsigned bytes_sent     = 0;
  int unsigned buffers_closed = 0;
  int unsigned config_writes  = 0;
  logic [3:0]  modes_seen     = 4'b0001;
  bit          no_idle        = 1'b0;

  xor_chain_stream_descrambler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure: stalls about a third of the cycles, except
  // during the no-idle stretch.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Advance the chain by one byte and queue the output it must produce.
  // Position 0 takes the seed from the length register instead of the chain;
  // a length of 0 makes every byte a one-byte buffer with seed 0.
  function automatic void descramble_predict(input byte_t value);
    byte_t       mul;
    byte_t       seed;
    logic [15:0] prod;
    byte_t       x;
    chain_out_t  res;
    mul  = (p_mode == MODE_TWO) ? RAMP_MUL_ALT : RAMP_MUL_STD;
    seed = (p_pos == '0) ? p_length[7:0] : p_chain;
    prod = p_pos[7:0] * mul;
    x    = value ^ KEY_BYTES[p_pos[3:0]*8 +: 8] ^ prod[7:0];
    res.data = x ^ seed;
    if (p_mode != MODE_PLAIN && (p_pos[3:0] == FIX_LANE_LO || p_pos[3:0] == FIX_LANE_HI))
      res.data = res.data ^ LANE_FIX;
    p_chain = x;
    // 32-bit compare so the increment cannot wrap; >= lets a cut-down length below the position still end it
    res.last = ({1'b0, p_pos} + 32'd1) >= {1'b0, p_length};
    p_pos    = res.last ? '0 : p_pos + 31'd1;
    expected_bytes.insert(expected_bytes.size(), res);
  endfunction

  // Output checker: every accepted output transaction against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    chain_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("output %02h with nothing expected", out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (last_byte !== want.last)
          report_mismatch($sformatf("last_byte %b, want %b", last_byte, want.last));
        if (want.last) buffers_closed++;
      end
    end
  end

  // Enter and leave at a falling edge; in_valid stays high on return so
  // back-to-back transactions need no extra assignment.
  task automatic send_byte(input byte_t value);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    descramble_predict(value);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every queued result has come out, plus some margin.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Both registers, one write per cycle, only with the pipe empty.
  task automatic set_config(input mode_t mode, input pos_t length);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_METHOD_MODE;
    cfg_data  <= CfgW'(mode);
    @(negedge clk);
    cfg_index <= REG_STREAM_LENGTH;
    cfg_data  <= length;
    @(negedge clk);
    cfg_we    <= 1'b0;
    p_mode   = mode;
    p_length = length;
    modes_seen[mode] = 1'b1;
    config_writes += 2;
  endtask

  // Reset values: mode 0, one-byte buffers seeded with 1.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  // Zero length acts as one with a zero seed.
  task automatic test_zero_length();
    set_config(MODE_PLAIN, '0);
    send_byte(8'hff);
    send_byte(8'h00);
  endtask

  // Lanes 5 and 6 take the fixup in a nonzero mode; buffer ends at 8.
  task automatic test_fixup_lanes();
    set_config(MODE_FIX_B, 31'd8);
    for (int i = 0; i < 8; i++) send_byte((i % 2) ? 8'hff : 8'h00);
  endtask

  // Alternate multiplier in mode 2.
  task automatic test_alt_multiplier();
    set_config(MODE_TWO, 31'd3);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7f);
  endtask

  // Maximum length, then cut below the current position mid-buffer: the
  // next byte must close the buffer.
  task automatic test_length_cut();
    set_config(MODE_FIX_A, LEN_MAX);
    for (int i = 0; i < 4; i++) send_byte(8'(i * 8'h55));
    set_config(MODE_FIX_A, 31'd2);
    send_byte(8'hc3);
  endtask

  // Mode switch mid-buffer affects only later bytes.
  task automatic test_mode_switch();
    set_config(MODE_TWO, 31'd6);
    send_byte(8'h3c);
    send_byte(8'ha5);
    set_config(MODE_PLAIN, 31'd6);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Random phases: a new mode and length each time, written whatever the
  // current position (so mid-buffer changes recur), mostly short buffers
  // with some zero, maximum and arbitrary 31-bit lengths. One long phase runs
  // with no idling on either side.
  task automatic test_random_buffers();
    int unsigned sent_here;
    int unsigned phase;
    int unsigned count;
    int unsigned pick;
    mode_t       mode;
    pos_t        length;
    sent_here = 0;
    phase     = 0;
    while (sent_here < RANDOM_BYTES) begin
      mode = mode_t'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 5)       length = '0;
      else if (pick < 10) length = LEN_MAX;
      else if (pick < 20) length = pos_t'($urandom);
      else                length = pos_t'($urandom_range(40, 1));
      set_config(mode, length);
      no_idle = (phase == 3);
      count = no_idle ? 60 : $urandom_range(60, 5);
      for (int i = 0; i < count; i++) send_byte(8'($urandom_range(255)));
      no_idle = 1'b0;
      sent_here += count;
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_zero_length();
    test_fixup_lanes();
    test_alt_multiplier();
    test_length_cut();
    test_mode_switch();
    test_random_buffers();

    wait_until_drained();
    repeat (8) @(negedge clk);
    if (expected_bytes.size() != 0) report_mismatch("results missing at end of run");

    $display("Checked %0d bytes and %0d buffer ends over %0d register writes.",
             bytes_sent, buffers_closed, config_writes);
    $display("Modes exercised (bit per mode): %b; mismatches: %0d.", modes_seen, err_count);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
